// ----- rtl/sha1mh_pkg.sv -----
// sha1mh_pkg: shared types, constants and round functions for the sha-1 hash unit
// no dependencies; used by sha1_message_hash_unit
package sha1mh_pkg;

  localparam int unsigned NUM_H = 5;
  localparam int unsigned BLK_WORDS = 16;

  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;
  localparam logic [7:0]  PAD_BYTE = 8'h80;

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_PAD   = 8'b0000_0010,
    ST_ZERO  = 8'b0000_0100,
    ST_LEN   = 8'b0000_1000,
    ST_LOADH = 8'b0001_0000,
    ST_ROUND = 8'b0010_0000,
    ST_FOLD  = 8'b0100_0000,
    ST_OUT   = 8'b1000_0000
  } state_t;

  typedef enum logic [1:0] {
    RG_CH  = 2'd0,
    RG_PA1 = 2'd1,
    RG_MAJ = 2'd2,
    RG_PA2 = 2'd3
  } round_grp_t;

  function automatic logic [31:0] h_init(input logic [2:0] idx);
    logic [31:0] v;
    case (idx)
      3'd0: v = 32'h67452301;
      3'd1: v = 32'hEFCDAB89;
      3'd2: v = 32'h98BADCFE;
      3'd3: v = 32'h10325476;
      3'd4: v = 32'hC3D2E1F0;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] round_f(input round_grp_t grp, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
    logic [31:0] v;
    case (grp)
      RG_CH:   v = (b & c) | (~b & d);
      RG_MAJ:  v = (b & c) | (b & d) | (c & d);
      default: v = b ^ c ^ d;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] round_k(input round_grp_t grp);
    logic [31:0] v;
    case (grp)
      RG_CH:   v = K0;
      RG_PA1:  v = K1;
      RG_MAJ:  v = K2;
      default: v = K3;
    endcase
    return v;
  endfunction

  // last block word holding the partial bytes, then the 0x80 marker
  function automatic logic [31:0] pad_word(input logic [1:0] nbytes, input logic [23:0] acc);
    logic [31:0] v;
    case (nbytes)
      2'd0:    v = {PAD_BYTE, 24'h0};
      2'd1:    v = {acc[7:0], PAD_BYTE, 16'h0};
      2'd2:    v = {acc[15:0], PAD_BYTE, 8'h0};
      default: v = {acc[23:0], PAD_BYTE};
    endcase
    return v;
  endfunction

endpackage

// ----- rtl/sha1mh_ram.sv -----
// sha1mh_ram: generic simple dual-port ram, one write and one registered read per cycle
// no dependencies
module sha1mh_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/sha1_message_hash_unit.sv -----
// sha1_message_hash_unit: sha-1 over a byte stream, digest out as five 32-bit words
// depends on sha1mh_pkg and sha1mh_ram (block word memory, chaining word memory)
//
//  channel | direction | tdata           | tuser             | tlast
//  s_*     | in        | data_byte[7:0]  | byte_present      | end_of_message
//  m_*     | out       | digest_word     | word_number[2:0]  | final_word
//
// a byte is taken whenever s_tvalid and s_tready are both high; each full 64-byte block then holds
// s_tready low through the chaining reads, 80 rounds at one round per cycle and the write-back
// end of message: 1 to 16 padding writes per block in one or two blocks, then a chaining read per digest word
// reset is synchronous; the chaining memory reads its initial values through valid bits
// a stalled m_tready holds the digest sequence; the last word waits while input resumes
module sha1_message_hash_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tuser,   // [0] byte_present
  input  logic        s_tlast,   // end_of_message
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] digest_word
  output logic [2:0]  m_tuser,   // [2:0] word_number
  output logic        m_tlast    // final_word
);

  sha1mh_pkg::state_t state;
  logic [60:0]  count;
  logic [23:0]  acc;
  logic         end_pending;
  logic         finishing;
  logic         two_blocks;
  logic [3:0]   ptr;
  logic [2:0]   cnt;
  logic [6:0]   rnd;
  logic         rd_pend;
  logic [31:0]  va, vb, vc, vd, ve;
  logic [31:0]  w_sr [sha1mh_pkg::BLK_WORDS];
  logic [sha1mh_pkg::NUM_H-1:0] hvalid;
  logic [2:0]   h_rd_addr;
  logic         h_rd_init;

  // block memory ports
  logic         blk_we;
  logic [3:0]   blk_waddr;
  logic [31:0]  blk_wdata;
  logic [3:0]   blk_raddr;
  logic [31:0]  blk_rdata;

  // chaining memory ports
  logic         h_we;
  logic [2:0]   h_waddr;
  logic [31:0]  h_wdata;
  logic [2:0]   h_raddr;
  logic [31:0]  h_rdata_raw;
  logic [31:0]  h_rdata;

  logic         in_acc;
  logic         out_issue;
  logic         out_load;
  logic [63:0]  bit_len;
  logic         two_blk_now;
  logic [3:0]   pad_idx;
  logic [31:0]  w_new;
  logic [31:0]  w_cur;
  logic [31:0]  t_sum;
  logic [31:0]  h_addend;
  sha1mh_pkg::round_grp_t grp;

  sha1mh_ram #(.WIDTH(32), .DEPTH(sha1mh_pkg::BLK_WORDS)) u_blk_ram (
    .clk   (clk),
    .we    (blk_we),
    .waddr (blk_waddr),
    .wdata (blk_wdata),
    .raddr (blk_raddr),
    .rdata (blk_rdata)
  );

  sha1mh_ram #(.WIDTH(32), .DEPTH(sha1mh_pkg::NUM_H)) u_h_ram (
    .clk   (clk),
    .we    (h_we),
    .waddr (h_waddr),
    .wdata (h_wdata),
    .raddr (h_raddr),
    .rdata (h_rdata_raw)
  );

  assign s_tready    = (state == sha1mh_pkg::ST_IDLE);
  assign in_acc      = s_tvalid && s_tready;
  assign bit_len     = {count, 3'b000};
  assign pad_idx     = count[5:2];
  assign two_blk_now = (count[5:3] == 3'b111);
  // an entry never written since the last digest reads as its initial value
  assign h_rdata     = h_rd_init ? sha1mh_pkg::h_init(h_rd_addr) : h_rdata_raw;

  assign out_issue = (state == sha1mh_pkg::ST_OUT) && !rd_pend && (!m_tvalid || m_tready);
  assign out_load  = (state == sha1mh_pkg::ST_OUT) && rd_pend;

  // message schedule: w_sr[j] holds w[r-1-j]
  assign w_new = {w_sr[2] ^ w_sr[7] ^ w_sr[13] ^ w_sr[15]} << 1
               | {31'h0, w_sr[2][31] ^ w_sr[7][31] ^ w_sr[13][31] ^ w_sr[15][31]};
  assign w_cur = (rnd < 7'd16) ? blk_rdata : w_new;

  always_comb begin
    if (rnd < 7'd20) begin
      grp = sha1mh_pkg::RG_CH;
    end else if (rnd < 7'd40) begin
      grp = sha1mh_pkg::RG_PA1;
    end else if (rnd < 7'd60) begin
      grp = sha1mh_pkg::RG_MAJ;
    end else begin
      grp = sha1mh_pkg::RG_PA2;
    end
  end

  assign t_sum = {va[26:0], va[31:27]} + sha1mh_pkg::round_f(grp, vb, vc, vd) + ve
               + sha1mh_pkg::round_k(grp) + w_cur;

  always_comb begin
    case (h_rd_addr)
      3'd0:    h_addend = va;
      3'd1:    h_addend = vb;
      3'd2:    h_addend = vc;
      3'd3:    h_addend = vd;
      default: h_addend = ve;
    endcase
  end

  // block memory write and read
  always_comb begin
    blk_we    = 1'b0;
    blk_waddr = ptr;
    blk_wdata = '0;
    blk_raddr = '0;
    case (state)
      sha1mh_pkg::ST_IDLE: begin
        blk_we    = in_acc && s_tuser && (count[1:0] == 2'd3);
        blk_waddr = pad_idx;
        blk_wdata = {acc, s_tdata};
      end
      sha1mh_pkg::ST_PAD: begin
        blk_we    = 1'b1;
        blk_waddr = pad_idx;
        blk_wdata = sha1mh_pkg::pad_word(count[1:0], acc);
      end
      sha1mh_pkg::ST_ZERO: begin
        blk_we    = 1'b1;
      end
      sha1mh_pkg::ST_LEN: begin
        blk_we    = 1'b1;
        blk_wdata = ptr[0] ? bit_len[31:0] : bit_len[63:32];
      end
      sha1mh_pkg::ST_ROUND: begin
        blk_raddr = rnd[3:0] + 4'd1;
      end
      default: begin
        blk_we = 1'b0;
      end
    endcase
  end

  // chaining memory: read one word a cycle in load and write-back, write back the sum in the next cycle
  always_comb begin
    h_raddr = (cnt == 3'd5) ? 3'd0 : cnt;
    h_we    = (state == sha1mh_pkg::ST_FOLD) && (cnt != 3'd0);
    h_waddr = h_rd_addr;
    h_wdata = h_rdata + h_addend;
  end

  always_ff @(posedge clk) begin
    h_rd_addr <= h_raddr;
    h_rd_init <= !hvalid[h_raddr];
    if (state == sha1mh_pkg::ST_ROUND) begin
      w_sr[0] <= w_cur;
      for (int j = 1; j < sha1mh_pkg::BLK_WORDS; j++) begin
        w_sr[j] <= w_sr[j-1];
      end
    end
    if (in_acc && s_tuser) begin
      acc <= {acc[15:0], s_tdata};
    end
    if (out_load) begin
      m_tdata <= h_rdata;
      m_tuser <= h_rd_addr;
      m_tlast <= (h_rd_addr == 3'd4);
    end
    case (state)
      sha1mh_pkg::ST_LOADH: begin
        if (cnt != 3'd0) begin
          case (h_rd_addr)
            3'd0:    va <= h_rdata;
            3'd1:    vb <= h_rdata;
            3'd2:    vc <= h_rdata;
            3'd3:    vd <= h_rdata;
            default: ve <= h_rdata;
          endcase
        end
      end
      sha1mh_pkg::ST_ROUND: begin
        va <= t_sum;
        vb <= va;
        vc <= {vb[1:0], vb[31:2]};
        vd <= vc;
        ve <= vd;
      end
      default: begin
        va <= va;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= sha1mh_pkg::ST_IDLE;
      count       <= '0;
      end_pending <= 1'b0;
      finishing   <= 1'b0;
      two_blocks  <= 1'b0;
      ptr         <= '0;
      cnt         <= '0;
      rnd         <= '0;
      rd_pend     <= 1'b0;
      hvalid      <= '0;
      m_tvalid    <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (h_we) begin
        hvalid[h_waddr] <= 1'b1;
      end
      case (state)
        sha1mh_pkg::ST_IDLE: begin
          if (in_acc) begin
            end_pending <= s_tlast;
            if (s_tuser) begin
              count <= count + 61'd1;
            end
            cnt <= '0;
            if (s_tuser && (count[5:0] == 6'd63)) begin
              state <= sha1mh_pkg::ST_LOADH;
            end else if (s_tlast) begin
              state <= sha1mh_pkg::ST_PAD;
            end
          end
        end
        sha1mh_pkg::ST_PAD: begin
          finishing  <= 1'b1;
          two_blocks <= two_blk_now;
          ptr        <= pad_idx + 4'd1;
          cnt        <= '0;
          if (two_blk_now && (pad_idx == 4'd15)) begin
            state <= sha1mh_pkg::ST_LOADH;
          end else if (!two_blk_now && (pad_idx == 4'd13)) begin
            state <= sha1mh_pkg::ST_LEN;
          end else begin
            state <= sha1mh_pkg::ST_ZERO;
          end
        end
        sha1mh_pkg::ST_ZERO: begin
          ptr <= ptr + 4'd1;
          cnt <= '0;
          if (two_blocks && (ptr == 4'd15)) begin
            state <= sha1mh_pkg::ST_LOADH;
          end else if (!two_blocks && (ptr == 4'd13)) begin
            state <= sha1mh_pkg::ST_LEN;
          end
        end
        sha1mh_pkg::ST_LEN: begin
          ptr <= ptr + 4'd1;
          cnt <= '0;
          if (ptr == 4'd15) begin
            state <= sha1mh_pkg::ST_LOADH;
          end
        end
        sha1mh_pkg::ST_LOADH: begin
          cnt <= cnt + 3'd1;
          rnd <= '0;
          if (cnt == 3'd5) begin
            state <= sha1mh_pkg::ST_ROUND;
          end
        end
        sha1mh_pkg::ST_ROUND: begin
          rnd <= rnd + 7'd1;
          cnt <= '0;
          if (rnd == 7'd79) begin
            state <= sha1mh_pkg::ST_FOLD;
          end
        end
        sha1mh_pkg::ST_FOLD: begin
          if (cnt == 3'd5) begin
            cnt <= '0;
            if (!finishing) begin
              state <= end_pending ? sha1mh_pkg::ST_PAD : sha1mh_pkg::ST_IDLE;
            end else if (two_blocks) begin
              // second padding block: zeros then the length
              two_blocks <= 1'b0;
              ptr        <= '0;
              state      <= sha1mh_pkg::ST_ZERO;
            end else begin
              state <= sha1mh_pkg::ST_OUT;
            end
          end else begin
            cnt <= cnt + 3'd1;
          end
        end
        sha1mh_pkg::ST_OUT: begin
          if (out_issue) begin
            rd_pend <= 1'b1;
            cnt     <= cnt + 3'd1;
          end
          if (out_load) begin
            rd_pend  <= 1'b0;
            m_tvalid <= 1'b1;
            if (h_rd_addr == 3'd4) begin
              // digest captured: back to initial chaining values
              hvalid      <= '0;
              count       <= '0;
              end_pending <= 1'b0;
              finishing   <= 1'b0;
              cnt         <= '0;
              state       <= sha1mh_pkg::ST_IDLE;
            end
          end
        end
        default: begin
          state <= sha1mh_pkg::ST_IDLE;
        end
      endcase
    end
  end

  a_round_end: assert property (@(posedge clk) disable iff (rst)
    (state == sha1mh_pkg::ST_ROUND) && (rnd == 7'd79) |=> (state == sha1mh_pkg::ST_FOLD))
    else $error("round counter did not hand over to write-back");

  a_blk_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == sha1mh_pkg::ST_ROUND) || (state == sha1mh_pkg::ST_LOADH) |-> !blk_we)
    else $error("block memory written during compression");

  a_h_write: assert property (@(posedge clk) disable iff (rst)
    h_we |-> (state == sha1mh_pkg::ST_FOLD) && (h_waddr == $past(h_raddr)))
    else $error("chaining write outside write-back or to wrong entry");

  a_out_free: assert property (@(posedge clk) disable iff (rst)
    out_load |-> !m_tvalid)
    else $error("digest word overwrote a word still waiting");

endmodule
